@@ design/lbs_pkg.sv @@
// shared types, constants and field widths for the skinning block
package lbs_pkg;

   localparam int MAX_JOINTS_DEF = 256;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int WEIGHT_FRAC    = 16;
   localparam int NUM_ELEMENTS   = 12;
   localparam int ADDR_CALC_W    = 16;
   localparam int JOINT_CMP_W    = 11;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   localparam int REQ_TDATA_W = 160;
   localparam int RSP_TDATA_W = 96;

   typedef enum logic {
      OP_WRITE     = 1'b0,
      OP_INFLUENCE = 1'b1
   } lbs_op_type;

   // one decoded word waiting for the back end
   typedef struct packed {
      lbs_op_type         op;
      logic               joint_ok;
      logic [7:0]         joint;
      logic [3:0]         element;
      logic [31:0]        value;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [16:0]        weight;
      logic               last;
   } lbs_cmd_type;

   typedef struct packed {
      logic idle;
      logic emitting;
   } lbs_back_status_type;

endpackage

@@ design/lbs_front.sv @@
// front end: takes request words, decodes and filters them, queues commands
module lbs_front #(
   parameter int MAX_JOINTS = lbs_pkg::MAX_JOINTS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [lbs_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic                             req_tuser,
   input  logic                             req_tlast,
   output logic                             cmd_valid,
   output lbs_pkg::lbs_cmd_type             cmd,
   input  logic                             cmd_pop
);
   import lbs_pkg::*;

   lbs_cmd_type              dec;
   logic                     keep;
   logic                     push;
   lbs_cmd_type              q_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [QUEUE_PTR_W:0]     count_ff;

   // field unpacking
   always_comb begin
      dec.op       = lbs_op_type'(req_tuser);
      dec.joint    = req_tdata[7:0];
      dec.element  = req_tdata[11:8];
      dec.value    = req_tdata[43:12];
      dec.pos_x    = signed'(req_tdata[75:44]);
      dec.pos_y    = signed'(req_tdata[107:76]);
      dec.pos_z    = signed'(req_tdata[139:108]);
      dec.weight   = req_tdata[156:140];
      dec.last     = req_tlast;
      dec.joint_ok = {3'b0, req_tdata[7:0]} < JOINT_CMP_W'(MAX_JOINTS);
   end

   // writes outside the palette are dropped here
   assign keep = (dec.op == OP_INFLUENCE) ||
                 (dec.joint_ok && (dec.element < 4'(NUM_ELEMENTS)));

   assign req_tready = (count_ff != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready && keep;
   assign cmd_valid  = (count_ff != '0);
   assign cmd        = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (cmd_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !cmd_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (!push && cmd_pop) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

@@ design/lbs_back.sv @@
// back end: palette memory, element sequencer, transform and weighted accumulation
module lbs_back #(
   parameter int MAX_JOINTS = lbs_pkg::MAX_JOINTS_DEF,
   parameter int FRAC_BITS  = lbs_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             cmd_valid,
   input  lbs_pkg::lbs_cmd_type             cmd,
   output logic                             cmd_pop,
   output lbs_pkg::lbs_back_status_type     status,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lbs_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tuser
);
   import lbs_pkg::*;

   localparam int DEPTH = MAX_JOINTS * NUM_ELEMENTS;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [1:0] ROW_OFFSET = 2'd3;
   localparam logic [1:0] COL_LAST   = 2'd2;
   localparam logic signed [63:0] T_POS = 64'sh0000_2000_0000_0000;
   localparam logic signed [63:0] T_NEG = -T_POS;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_EMIT} state_type;

   function automatic logic [AW-1:0] elem_addr(input logic [7:0] j, input logic [3:0] e);
      logic [ADDR_CALC_W-1:0] full;
      full = ADDR_CALC_W'(j) * ADDR_CALC_W'(NUM_ELEMENTS) + ADDR_CALC_W'(e);
      return full[AW-1:0];
   endfunction

   // {saturated, value}
   function automatic logic [64:0] sat_add(input logic signed [63:0] a,
                                           input logic signed [63:0] b);
      logic signed [64:0] full;
      full = {a[63], a} + {b[63], b};
      if (full[64] != full[63]) begin
         return full[64] ? {1'b1, 1'b1, 63'b0} : {1'b1, 1'b0, {63{1'b1}}};
      end
      return {1'b0, full[63:0]};
   endfunction

   // {clipped, value}
   function automatic logic [32:0] clip32(input logic signed [63:0] v);
      if (v[63:31] == {33{v[63]}}) begin
         return {1'b0, v[31:0]};
      end
      return v[63] ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7fff_ffff};
   endfunction

   state_type           state_ff;
   lbs_cmd_type         item_ff;
   logic [1:0]          row_ff;
   logic [1:0]          col_ff;
   logic                rsp_valid_ff;
   logic [95:0]         rsp_data_ff;
   logic                rsp_sat_ff;
   logic                emit_fire;
   logic                issue;
   logic                issue_fin;
   logic                mem_we;
   logic [AW-1:0]       wr_addr;
   logic [AW-1:0]       rd_addr;
   logic [31:0]         palette_mem [DEPTH];
   logic [31:0]         rd_ff;

   // pipeline: read -> term -> column total -> weighted -> sums
   logic                v1_ff, v2_ff, v3_ff, v4_ff;
   logic                fin1_ff, fin2_ff, fin3_ff, fin4_ff;
   logic [1:0]          r1_ff, r2_ff;
   logic [1:0]          c1_ff, c2_ff, c3_ff, c4_ff;
   logic signed [31:0]  m1;
   logic signed [31:0]  pos_sel;
   logic signed [63:0]  prod;
   logic signed [63:0]  term_in;
   logic signed [63:0]  term_ff;
   logic signed [63:0]  t_ff;
   logic signed [63:0]  tfull;
   logic signed [46:0]  tclip_in;
   logic                tclip_sat;
   logic signed [46:0]  tclip_ff;
   logic signed [17:0]  w_s;
   logic signed [64:0]  wprod_full;
   logic signed [63:0]  wprod_ff;
   logic signed [63:0]  addend;
   logic signed [63:0]  sum_x_ff, sum_y_ff, sum_z_ff;
   logic signed [63:0]  sum_sel;
   logic [64:0]         sum_new;
   logic                sat_seen_ff;
   logic [32:0]         cx, cy, cz;

   assign cmd_pop   = (state_ff == ST_IDLE) && cmd_valid;
   assign issue     = (state_ff == ST_RUN);
   assign issue_fin = (row_ff == ROW_OFFSET) && (col_ff == COL_LAST);
   assign mem_we    = cmd_pop && (cmd.op == OP_WRITE);
   assign wr_addr   = elem_addr(cmd.joint, cmd.element);
   assign rd_addr   = elem_addr(item_ff.joint, 4'(row_ff) * 4'd3 + 4'(col_ff));
   assign emit_fire = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);

   assign status.idle     = (state_ff == ST_IDLE);
   assign status.emitting = (state_ff == ST_EMIT);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;

   // palette memory, one write and one read a cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         palette_mem[wr_addr] <= cmd.value;
      end
      rd_ff <= palette_mem[rd_addr];
   end

   // sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // result register: loaded by the emit step, freed once taken
         if (emit_fire) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= {cz[31:0], cy[31:0], cx[31:0]};
            rsp_sat_ff   <= sat_seen_ff | cx[32] | cy[32] | cz[32];
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (cmd_pop && (cmd.op == OP_INFLUENCE)) begin
                  item_ff  <= cmd;
                  row_ff   <= '0;
                  col_ff   <= '0;
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               row_ff <= row_ff + 1'b1;
               if (row_ff == ROW_OFFSET) begin
                  col_ff <= col_ff + 1'b1;
               end
               if (issue_fin) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (v4_ff && fin4_ff) begin
                  state_ff <= item_ff.last ? ST_EMIT : ST_IDLE;
               end
            end
            ST_EMIT: begin
               if (emit_fire) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // datapath combinational parts
   always_comb begin
      m1 = item_ff.joint_ok ? signed'(rd_ff) : 32'sd0;
      case (r1_ff)
         2'd0:    pos_sel = item_ff.pos_x;
         2'd1:    pos_sel = item_ff.pos_y;
         default: pos_sel = item_ff.pos_z;
      endcase
      prod    = pos_sel * m1;
      term_in = (r1_ff == ROW_OFFSET) ? signed'({{32{m1[31]}}, m1}) : (prod >>> FRAC_BITS);

      tfull     = ((r2_ff == '0) ? 64'sd0 : t_ff) + term_ff;
      tclip_sat = 1'b0;
      if (tfull > T_POS) begin
         tclip_in  = T_POS[46:0];
         tclip_sat = 1'b1;
      end else if (tfull < T_NEG) begin
         tclip_in  = T_NEG[46:0];
         tclip_sat = 1'b1;
      end else begin
         tclip_in  = tfull[46:0];
      end

      w_s        = signed'({1'b0, item_ff.weight});
      wprod_full = tclip_ff * w_s;
      addend     = wprod_ff >>> WEIGHT_FRAC;

      case (c4_ff)
         2'd0:    sum_sel = sum_x_ff;
         2'd1:    sum_sel = sum_y_ff;
         default: sum_sel = sum_z_ff;
      endcase
      sum_new = sat_add(sum_sel, addend);

      cx = clip32(sum_x_ff);
      cy = clip32(sum_y_ff);
      cz = clip32(sum_z_ff);
   end

   // pipeline valids and tags
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff && (r2_ff == ROW_OFFSET);
         v4_ff <= v3_ff;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      r1_ff    <= row_ff;
      c1_ff    <= col_ff;
      fin1_ff  <= issue_fin;
      r2_ff    <= r1_ff;
      c2_ff    <= c1_ff;
      fin2_ff  <= fin1_ff;
      term_ff  <= term_in;
      c3_ff    <= c2_ff;
      fin3_ff  <= fin2_ff;
      c4_ff    <= c3_ff;
      fin4_ff  <= fin3_ff;
      wprod_ff <= wprod_full[63:0];
      if (v2_ff) begin
         t_ff     <= tfull;
         tclip_ff <= tclip_in;
      end
   end

   // running sums and sticky clip flag
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_x_ff    <= '0;
         sum_y_ff    <= '0;
         sum_z_ff    <= '0;
         sat_seen_ff <= 1'b0;
      end else if (emit_fire) begin
         sum_x_ff    <= '0;
         sum_y_ff    <= '0;
         sum_z_ff    <= '0;
         sat_seen_ff <= 1'b0;
      end else begin
         if (v2_ff && (r2_ff == ROW_OFFSET) && tclip_sat) begin
            sat_seen_ff <= 1'b1;
         end
         if (v4_ff) begin
            case (c4_ff)
               2'd0:    sum_x_ff <= sum_new[63:0];
               2'd1:    sum_y_ff <= sum_new[63:0];
               default: sum_z_ff <= sum_new[63:0];
            endcase
            if (sum_new[64]) begin
               sat_seen_ff <= 1'b1;
            end
         end
      end
   end

endmodule

@@ design/linear_blend_skinning_core.sv @@
// top level of the linear blend skinning core
//
// skins vertex positions against a palette of 4x3 affine joint matrices in
// q16.16. a request word with tuser low writes one palette element; a word
// with tuser high is one influence of a vertex: a dispatch step, then 12
// palette reads through the single memory read port, one per matrix element,
// into a 4-stage multiply and accumulate pipeline. the influence marked by
// tlast then hands its result word to the output register in an emit step,
// which waits while a previous result is still not taken. a four-word
// command queue between the front and the back end keeps the request side
// accepting while the back end works.
// writes to an element above 11 or a joint beyond the palette are dropped;
// an influence of such a joint adds nothing but its tlast still gives a result.
// a vertex without influences must be sent as one influence of weight zero.
// palette entries read before they are written return unknown data.
module linear_blend_skinning_core #(
   parameter int MAX_JOINTS = lbs_pkg::MAX_JOINTS_DEF,
   parameter int FRAC_BITS  = lbs_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // joint[7:0] element[11:8] value[43:12] pos_x[75:44] pos_y[107:76]
   // pos_z[139:108] weight[156:140], zero fill above
   input  logic [lbs_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // opcode: 0 palette write, 1 influence
   input  logic                             req_tuser,
   // last influence of the vertex
   input  logic                             req_tlast,
   // response channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // out_x[31:0] out_y[63:32] out_z[95:64]
   output logic [lbs_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // saturated
   output logic                             rsp_tuser
);
   import lbs_pkg::*;

   // front to back command word
   logic                cmd_valid;
   lbs_cmd_type         cmd;
   logic                cmd_pop;
   lbs_back_status_type back_status;

   // decode, filter and queue the incoming words
   lbs_front #(
      .MAX_JOINTS (MAX_JOINTS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   // palette, transform, weighting and the vertex sums
   lbs_back #(
      .MAX_JOINTS (MAX_JOINTS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .status     (back_status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // no result word right after reset
   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word present right after reset");

   // a new result word only comes out of the emit step
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(back_status.emitting))
      else $error("result word raised outside the emit step");

   // back end takes a command only when one is queued and it is free
   a_pop_when_ready: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (cmd_valid && back_status.idle))
      else $error("command taken from an empty queue or by a busy back end");

endmodule

@@ tb/tb_linear_blend_skinning_core.sv @@
// self-checking testbench for linear_blend_skinning_core with a fixed-point scoreboard
module tb_linear_blend_skinning_core;
   import lbs_pkg::*;

   // q16.16 and 64-bit bounds used by the predictor
   localparam int     ONE_Q16   = 32'sh0001_0000;
   localparam int     I32_TOP   = 32'sh7FFF_FFFF;
   localparam int     I32_BOT   = 32'sh8000_0000;
   localparam longint I64_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint I64_MIN   = 64'sh8000_0000_0000_0000;
   localparam longint L32_MAX   = 64'sh0000_0000_7FFF_FFFF;
   localparam longint L32_MIN   = -64'sh0000_0000_8000_0000;
   localparam longint TERM_CLIP = 64'sh0000_2000_0000_0000;   // 2^45

   // run length and watchdog
   localparam int RANDOM_WORDS   = 985;
   localparam int DRAIN_CYCLES   = 200;
   localparam int WATCHDOG_LIMIT = 2000;

   // one request word as the block sees it
   typedef struct {
      lbs_op_type  op;
      bit [7:0]    joint;
      bit [3:0]    element;
      int          value;
      int          pos_x;
      int          pos_y;
      int          pos_z;
      bit [16:0]   weight;
      bit          last;
   } req_item_type;

   // one skinned vertex as it should leave the block
   typedef struct {
      logic [31:0] out_x;
      logic [31:0] out_y;
      logic [31:0] out_z;
      logic        saturated;
   } skinned_vertex_type;

   // scoreboard: keeps its own palette and running sums, predicts each vertex
   class vertex_scoreboard_type;
      int                 palette [MAX_JOINTS_DEF * NUM_ELEMENTS];
      longint             mat [NUM_ELEMENTS];
      longint             acc [3];
      bit                 clip_seen;
      bit                 word_clip;
      skinned_vertex_type skinned_q [$];
      int                 errors;

      function new();
         foreach (palette[i]) palette[i] = 0;
         acc       = '{0, 0, 0};
         clip_seen = 0;
         errors    = 0;
      endfunction

      // 64-bit add that sticks at the rails
      function longint sat_sum(longint a, longint b);
         if (b > 0 && a > I64_MAX - b) begin
            clip_seen = 1;
            return I64_MAX;
         end
         if (b < 0 && a < I64_MIN - b) begin
            clip_seen = 1;
            return I64_MIN;
         end
         return a + b;
      endfunction

      // weighted contribution of one column of p * M
      function longint column_term(longint x, longint y, longint z, int c, longint w);
         longint t;
         t = ((x * mat[c]) >>> FRAC_BITS_DEF) + ((y * mat[3 + c]) >>> FRAC_BITS_DEF)
           + ((z * mat[6 + c]) >>> FRAC_BITS_DEF) + mat[9 + c];
         if (t > TERM_CLIP) begin
            clip_seen = 1;
            t = TERM_CLIP;
         end
         if (t < -TERM_CLIP) begin
            clip_seen = 1;
            t = -TERM_CLIP;
         end
         return (t * w) >>> WEIGHT_FRAC;
      endfunction

      function logic [31:0] clip_word(longint v);
         if (v > L32_MAX) begin
            word_clip = 1;
            v = L32_MAX;
         end
         if (v < L32_MIN) begin
            word_clip = 1;
            v = L32_MIN;
         end
         return v[31:0];
      endfunction

      // note one accepted request word
      function void note_word(req_item_type it);
         longint             x;
         longint             y;
         longint             z;
         longint             w;
         int                 base;
         skinned_vertex_type v;
         base = int'(it.joint) * NUM_ELEMENTS;
         if (it.op == OP_WRITE) begin
            if (it.element < NUM_ELEMENTS && int'(it.joint) < MAX_JOINTS_DEF)
               palette[base + it.element] = it.value;
            return;
         end
         for (int i = 0; i < NUM_ELEMENTS; i++)
            mat[i] = (int'(it.joint) < MAX_JOINTS_DEF) ? longint'(palette[base + i]) : 0;
         x = it.pos_x;
         y = it.pos_y;
         z = it.pos_z;
         w = longint'(it.weight);
         for (int c = 0; c < 3; c++)
            acc[c] = sat_sum(acc[c], column_term(x, y, z, c, w));
         if (!it.last)
            return;
         word_clip   = clip_seen;
         v.out_x     = clip_word(acc[0]);
         v.out_y     = clip_word(acc[1]);
         v.out_z     = clip_word(acc[2]);
         v.saturated = word_clip;
         skinned_q   = {skinned_q, v};
         acc       = '{0, 0, 0};
         clip_seen = 0;
      endfunction

      // compare one accepted result word against the oldest vertex
      function void check_vertex(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                                 logic sat);
         skinned_vertex_type e;
         if (skinned_q.size() == 0) begin
            $error("result word with no vertex pending: x %0d y %0d z %0d sat %0b",
                   $signed(ox), $signed(oy), $signed(oz), sat);
            errors++;
            return;
         end
         e = skinned_q.pop_front();
         if (ox !== e.out_x) begin
            $error("out_x: expected %0d, got %0d", $signed(e.out_x), $signed(ox));
            errors++;
         end
         if (oy !== e.out_y) begin
            $error("out_y: expected %0d, got %0d", $signed(e.out_y), $signed(oy));
            errors++;
         end
         if (oz !== e.out_z) begin
            $error("out_z: expected %0d, got %0d", $signed(e.out_z), $signed(oz));
            errors++;
         end
         if (sat !== e.saturated) begin
            $error("saturated: expected %0b, got %0b", e.saturated, sat);
            errors++;
         end
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata = '0;
   logic                    req_tuser = 1'b0;
   logic                    req_tlast = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic                    rsp_tuser;

   vertex_scoreboard_type sb;

   // sender state: burst pacing and which joints are fully loaded
   int        burst_left = 0;
   int        sent       = 0;
   bit [11:0] loaded [256];
   bit [7:0]  live_joints [$];

   // receiver stall pattern state
   int        run_left  = 0;
   int        hold_left = 0;

   // watchdog
   int        idle_cycles = 0;

   linear_blend_skinning_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      // joint, element, value, pos_x, pos_y, pos_z, weight, zero fill
      .req_tdata  (req_tdata),
      // opcode
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      // out_x, out_y, out_z
      .rsp_tdata  (rsp_tdata),
      // saturated
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------- values

   // coordinates: mostly modest, some wide, a few full range and rails
   function automatic int rand_coord();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return int'($urandom_range(0, 2 << 20)) - (1 << 20);
         6, 7:             return int'($urandom_range(0, 2 << 24)) - (1 << 24);
         8:                return int'($urandom);
         default: begin
            case ($urandom_range(0, 3))
               0:       return I32_TOP;
               1:       return I32_BOT;
               2:       return 0;
               default: return -1;
            endcase
         end
      endcase
   endfunction

   // matrix elements: mostly within a few units, some full range
   function automatic int rand_elem_value();
      case ($urandom_range(0, 7))
         0, 1, 2, 3, 4: return int'($urandom_range(0, 2 << 17)) - (1 << 17);
         5:             return int'($urandom_range(0, 2 << 22)) - (1 << 22);
         6:             return int'($urandom);
         default:       return $urandom_range(0, 1) ? I32_TOP : I32_BOT;
      endcase
   endfunction

   // weights: unit, zero, in range and above one
   function automatic bit [16:0] rand_weight();
      case ($urandom_range(0, 9))
         0:       return 17'd0;
         1:       return 17'd65536;
         2, 3:    return 17'($urandom_range(65537, 131071));
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   // ---------------------------------------------------------------- driving

   // one request word, with burst and gap pacing on the sender side
   task automatic send_word(input req_item_type it);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         // now and then a long stretch with no gaps at all
         burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.op;
      req_tlast  <= it.last;
      req_tdata  <= {3'b000, it.weight, it.pos_z, it.pos_y, it.pos_x, it.value,
                     it.element, it.joint};
      do @(posedge clock); while (!req_tready);
      burst_left--;
      sent++;
   endtask

   // palette write; the other fields carry noise
   task automatic put_write(input bit [7:0] j, input bit [3:0] e, input int v);
      req_item_type it;
      it.op      = OP_WRITE;
      it.joint   = j;
      it.element = e;
      it.value   = v;
      it.pos_x   = int'($urandom);
      it.pos_y   = int'($urandom);
      it.pos_z   = int'($urandom);
      it.weight  = 17'($urandom);
      it.last    = $urandom_range(0, 1);
      send_word(it);
      // a joint becomes usable for influences once all twelve elements are set
      if (e < NUM_ELEMENTS && loaded[j] != 12'hFFF) begin
         loaded[j][e] = 1'b1;
         if (loaded[j] == 12'hFFF)
            live_joints = {live_joints, j};
      end
   endtask

   task automatic put_influence(input bit [7:0] j, input bit [16:0] w, input bit lst,
                                input int x, input int y, input int z);
      req_item_type it;
      it.op      = OP_INFLUENCE;
      it.joint   = j;
      it.element = 4'($urandom);
      it.value   = int'($urandom);
      it.pos_x   = x;
      it.pos_y   = y;
      it.pos_z   = z;
      it.weight  = w;
      it.last    = lst;
      send_word(it);
   endtask

   // fill a whole joint, diagonal near one
   task automatic load_joint(input bit [7:0] j);
      int v;
      for (int i = 0; i < NUM_ELEMENTS; i++) begin
         if ((i == 0 || i == 4 || i == 8) && $urandom_range(0, 3) != 0)
            v = ONE_Q16 + int'($urandom_range(0, 8192)) - 4096;
         else
            v = rand_elem_value();
         put_write(j, 4'(i), v);
      end
   endtask

   function automatic bit [7:0] any_live();
      return live_joints[$urandom_range(0, live_joints.size() - 1)];
   endfunction

   // ---------------------------------------------------------------- receiver

   // runs of ready with stalls between, sometimes a long calm stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= 1'b1;
         if (run_left > 0) begin
            run_left--;
         end else if ($urandom_range(0, 7) == 0) begin
            run_left  = 300;
            hold_left = 0;
         end else begin
            run_left  = $urandom_range(0, 30);
            hold_left = $urandom_range(1, 12);
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   // note accepted requests and check accepted results at the same edge
   always @(posedge clock) begin
      req_item_type seen;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            seen.op      = lbs_op_type'(req_tuser);
            seen.joint   = req_tdata[7:0];
            seen.element = req_tdata[11:8];
            seen.value   = req_tdata[43:12];
            seen.pos_x   = req_tdata[75:44];
            seen.pos_y   = req_tdata[107:76];
            seen.pos_z   = req_tdata[139:108];
            seen.weight  = req_tdata[156:140];
            seen.last    = req_tlast;
            sb.note_word(seen);
         end
         if (rsp_tvalid && rsp_tready)
            sb.check_vertex(rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64], rsp_tuser);
      end
   end

   // watchdog: too long without any word moving on either side
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   initial begin
      int         directed_end;
      int         pick;
      int         n;
      bit         paused;
      bit [7:0]   j;
      sb = new();
      foreach (loaded[i]) loaded[i] = '0;
      paused = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // palette setup: identity at joint 0, rails at joint 255, mixed elsewhere
      for (int i = 0; i < NUM_ELEMENTS; i++)
         put_write(8'd0, 4'(i), (i == 0 || i == 4 || i == 8) ? ONE_Q16 : 0);
      for (int i = 0; i < NUM_ELEMENTS; i++)
         put_write(8'd255, 4'(i), (i % 2) ? I32_BOT : I32_TOP);
      load_joint(8'h55);
      load_joint(8'hAA);

      // directed: ignored writes to elements past the matrix
      put_write(8'd0, 4'd12, 32'sh5A5A_A5A5);
      put_write(8'd0, 4'd15, I32_BOT);
      // identity gives back the position
      put_influence(8'd0, 17'd65536, 1'b1, 32'sh0001_8000, -32'sh0002_0000, 32'sh0003_0000);
      put_influence(8'd0, 17'd65536, 1'b1, I32_TOP, I32_TOP, I32_TOP);
      put_influence(8'd0, 17'd65536, 1'b1, I32_BOT, I32_BOT, I32_BOT);
      // vertex with no influences, sent as one zero-weight influence
      put_influence(8'd0, 17'd0, 1'b1, 0, 0, 0);
      put_influence(8'd255, 17'd0, 1'b1, I32_TOP, I32_BOT, I32_TOP);
      // rail matrix, weight above one: term clip and output clip
      put_influence(8'd255, 17'd131071, 1'b1, I32_TOP, I32_TOP, I32_BOT);
      put_influence(8'd0, 17'd131071, 1'b1, 32'sh0000_4000, -32'sh0000_4000, 32'sh0001_0000);
      // two and three influence vertices
      put_influence(8'd0, 17'd32768, 1'b0, 32'sh0002_0000, 32'sh0001_0000, -32'sh0001_0000);
      put_influence(8'h55, 17'd32768, 1'b1, 32'sh0002_0000, 32'sh0001_0000, -32'sh0001_0000);
      put_influence(8'hAA, 17'd20000, 1'b0, rand_coord(), rand_coord(), rand_coord());
      put_influence(8'd255, 17'd1, 1'b0, I32_BOT, 0, I32_TOP);
      put_influence(8'd0, 17'd45535, 1'b1, rand_coord(), rand_coord(), rand_coord());
      // new translation on joint 0 shows up in the next vertex
      put_write(8'd0, 4'd9, ONE_Q16);
      put_write(8'd0, 4'd11, -ONE_Q16);
      put_influence(8'd0, 17'd65536, 1'b1, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
      directed_end = sent;

      // random part: mostly whole vertices, some palette traffic and broken runs
      while (sent < directed_end + RANDOM_WORDS) begin
         // hold off once until every pending vertex has come back
         if (!paused && sent >= directed_end + RANDOM_WORDS / 2) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while (sb.skinned_q.size() != 0);
            burst_left = 0;
            paused     = 1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            load_joint(8'($urandom));
         end else if (pick < 12) begin
            j = $urandom_range(0, 1) ? any_live() : 8'($urandom);
            put_write(j, 4'($urandom_range(0, 15)), rand_elem_value());
         end else if (pick < 90) begin
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++)
               put_influence(any_live(), rand_weight(), k == n - 1,
                             rand_coord(), rand_coord(), rand_coord());
         end else begin
            // stray influence: may end a vertex early or run into the next one
            put_influence(any_live(), rand_weight(), $urandom_range(0, 1),
                          rand_coord(), rand_coord(), rand_coord());
         end
      end

      // drain: every vertex back, then let the back end settle
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.skinned_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
